// ===== rtl/core/arpc_pkg.sv =====
// Package for the ARP cache responder: action codes, status codes, register
// indexes, the queued command type and the back-end state type.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package arpc_pkg;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_PACKET = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_PKT = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_OWN_IP   = 2'd0,
    REG_OWN_MAC  = 2'd1,
    REG_SWEEP_IV = 2'd2,
    REG_MAX_AGE  = 2'd3
  } reg_index_t;

  localparam logic [15:0] ETH_HW_TYPE = 16'h0001;
  localparam logic [15:0] IPV4_PROTO  = 16'h0800;
  localparam logic [7:0]  ETH_HW_LEN  = 8'd6;
  localparam logic [7:0]  IPV4_LEN    = 8'd4;
  localparam logic [15:0] OP_REQUEST  = 16'd1;
  localparam logic [15:0] SWEEP_RESET = 16'd60;
  localparam logic [15:0] AGE_RESET   = 16'd600;

  // Classified command passed from the front end to the back end.
  typedef struct packed {
    action_t     action;
    logic        bad_packet;
    logic        want_reply;
    logic [31:0] ip_address;
    logic [47:0] mac;
    logic        is_dynamic;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SWEEP,
    BK_SEARCH,
    BK_WRITE,
    BK_DONE
  } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/arpc_front.sv =====
// Front end of the ARP cache responder: accepts items, checks the packet
// header and the reply condition, and pushes a command into a one-deep queue.
// Depends on arpc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module arpc_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic [1:0]      action,
  input  wire logic [31:0]     ip_address,
  input  wire logic [47:0]     sender_mac,
  input  wire logic            is_dynamic,
  input  wire logic [15:0]     hw_type,
  input  wire logic [15:0]     proto_type,
  input  wire logic [7:0]      hw_len,
  input  wire logic [7:0]      proto_len,
  input  wire logic [15:0]     opcode,
  input  wire logic [31:0]     target_ip,
  input  wire logic [31:0]     own_ip,
  output logic                 cmd_valid,
  output arpc_pkg::cmd_t       cmd,
  input  wire logic            cmd_pop
);

  arpc_pkg::cmd_t cmd_new;
  logic           full;
  logic           header_ok;

  // Only one item is in the block at a time; the queue entry stays
  // occupied until the back end reports its result.
  assign busy      = full;
  assign cmd_valid = full;

  always_comb begin
    header_ok = (hw_type == arpc_pkg::ETH_HW_TYPE) && (proto_type == arpc_pkg::IPV4_PROTO)
             && (hw_len == arpc_pkg::ETH_HW_LEN) && (proto_len == arpc_pkg::IPV4_LEN);
    cmd_new.action     = arpc_pkg::action_t'(action);
    cmd_new.bad_packet = (action == arpc_pkg::ACT_PACKET) && !header_ok;
    cmd_new.want_reply = (action == arpc_pkg::ACT_PACKET) && header_ok
                      && (opcode == arpc_pkg::OP_REQUEST) && (target_ip == own_ip);
    cmd_new.ip_address = ip_address;
    cmd_new.mac        = sender_mac;
    cmd_new.is_dynamic = (action == arpc_pkg::ACT_PACKET) ? 1'b1 : is_dynamic;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (start && !full) begin
      full <= 1'b1;
    end else if (cmd_pop) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !full) begin
      cmd <= cmd_new;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/arpc_back.sv =====
// Back end of the ARP cache responder: owns the table, the clock of seconds,
// and runs the sweep, search and write steps one entry per cycle.
// Depends on arpc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module arpc_back #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  input  wire arpc_pkg::cmd_t cmd,
  output logic                cmd_pop,
  input  wire logic [15:0]    sweep_interval_s,
  input  wire logic [15:0]    max_age_s,
  output logic                done,
  output logic                hit,
  output logic [47:0]         found_mac,
  output logic                send_reply,
  output logic [47:0]         reply_mac,
  output logic [31:0]         reply_ip,
  output logic [1:0]          status
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam logic [IW:0] LAST = (IW+1)'(TABLE_ENTRIES - 1);

  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [TABLE_ENTRIES-1:0] entry_is_dynamic;
  logic [31:0] entry_ip    [TABLE_ENTRIES];
  logic [47:0] entry_mac   [TABLE_ENTRIES];
  logic [31:0] entry_stamp [TABLE_ENTRIES];
  logic [31:0] now_seconds;
  logic [31:0] last_sweep;

  arpc_pkg::back_state_t state, state_next;
  logic [IW-1:0] idx;
  logic          found, free_seen;
  logic [IW-1:0] found_idx, free_idx;
  logic          sweep_due, entry_old, ip_match, at_last;

  assign at_last   = ({1'b0, idx} == LAST);
  assign sweep_due = {1'b0, now_seconds} > ({1'b0, last_sweep} + 33'(sweep_interval_s));
  assign entry_old = {1'b0, now_seconds} > ({1'b0, entry_stamp[idx]} + 33'(max_age_s));
  assign ip_match  = entry_valid[idx] && (entry_ip[idx] == cmd.ip_address);

  always_comb begin
    state_next = state;
    case (state)
      arpc_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          if (cmd.action == arpc_pkg::ACT_TICK || cmd.bad_packet) begin
            state_next = arpc_pkg::BK_DONE;
          end else if (sweep_due) begin
            state_next = arpc_pkg::BK_SWEEP;
          end else begin
            state_next = arpc_pkg::BK_SEARCH;
          end
        end
      end
      arpc_pkg::BK_SWEEP:  if (at_last) state_next = arpc_pkg::BK_SEARCH;
      arpc_pkg::BK_SEARCH: begin
        if (ip_match || at_last) begin
          state_next = arpc_pkg::BK_WRITE;
        end
      end
      arpc_pkg::BK_WRITE:  state_next = arpc_pkg::BK_DONE;
      arpc_pkg::BK_DONE:   state_next = arpc_pkg::BK_IDLE;
      default:             state_next = arpc_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = (state == arpc_pkg::BK_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arpc_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid      <= TABLE_ENTRIES'(1);
      entry_is_dynamic <= '0;
      entry_ip[0]      <= 32'hFFFF_FFFF;
      entry_mac[0]     <= 48'hFFFF_FFFF_FFFF;
      entry_stamp[0]   <= '0;
      now_seconds      <= '0;
      last_sweep       <= '0;
      idx              <= '0;
      found            <= 1'b0;
      free_seen        <= 1'b0;
      found_idx        <= '0;
      free_idx         <= '0;
      done             <= 1'b0;
      hit              <= 1'b0;
      found_mac        <= '0;
      send_reply       <= 1'b0;
      reply_mac        <= '0;
      reply_ip         <= '0;
      status           <= arpc_pkg::ST_OK;
    end else begin
      done <= 1'b0;
      case (state)
        arpc_pkg::BK_IDLE: begin
          idx       <= '0;
          found     <= 1'b0;
          free_seen <= 1'b0;
          hit        <= 1'b0;
          found_mac  <= '0;
          send_reply <= cmd.want_reply;
          reply_mac  <= cmd.want_reply ? cmd.mac : 48'd0;
          reply_ip   <= cmd.want_reply ? cmd.ip_address : 32'd0;
          status     <= cmd.bad_packet ? arpc_pkg::ST_BAD_PKT : arpc_pkg::ST_OK;
          if (cmd_valid && cmd.action == arpc_pkg::ACT_TICK &&
              now_seconds != 32'hFFFF_FFFF) begin
            now_seconds <= now_seconds + 32'd1;
          end
          if (cmd_valid && cmd.action != arpc_pkg::ACT_TICK && !cmd.bad_packet
              && sweep_due) begin
            last_sweep <= now_seconds;
          end
        end
        arpc_pkg::BK_SWEEP: begin
          if (entry_valid[idx] && entry_is_dynamic[idx] && entry_old) begin
            entry_valid[idx] <= 1'b0;
          end
          idx <= at_last ? '0 : idx + 1'b1;
        end
        arpc_pkg::BK_SEARCH: begin
          if (ip_match) begin
            found     <= 1'b1;
            found_idx <= idx;
          end
          if (!entry_valid[idx] && !free_seen) begin
            free_seen <= 1'b1;
            free_idx  <= idx;
          end
          idx <= idx + 1'b1;
        end
        arpc_pkg::BK_WRITE: begin
          done <= 1'b1;
          if (cmd.action == arpc_pkg::ACT_LOOKUP) begin
            if (found) begin
              hit                    <= 1'b1;
              found_mac              <= entry_mac[found_idx];
              entry_stamp[found_idx] <= now_seconds;
            end
          end else if (found || free_seen) begin
            entry_valid[found ? found_idx : free_idx]      <= 1'b1;
            entry_is_dynamic[found ? found_idx : free_idx] <= cmd.is_dynamic;
            entry_ip[found ? found_idx : free_idx]         <= cmd.ip_address;
            entry_mac[found ? found_idx : free_idx]        <= cmd.mac;
            entry_stamp[found ? found_idx : free_idx]      <= now_seconds;
          end else begin
            status <= arpc_pkg::ST_FULL;
          end
        end
        arpc_pkg::BK_DONE: begin
          // Ticks and bad packets report here; others reported at WRITE.
          if (cmd.action == arpc_pkg::ACT_TICK || cmd.bad_packet) begin
            done <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // The done strobe never stays high on consecutive clock edges.
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("double result");
  // A hit only comes from a lookup.
  a_hit_lookup: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (cmd.action == arpc_pkg::ACT_LOOKUP)) else $error("stray hit");
  // The seconds counter never wraps back to zero.
  a_no_wrap: assert property (@(posedge clk) disable iff (rst)
    ($past(now_seconds) == 32'hFFFF_FFFF) |-> (now_seconds == 32'hFFFF_FFFF))
    else $error("time wrapped");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/arp_cache_responder.sv =====
// Top level of the ARP cache responder: configuration registers, front end
// and back end. Depends on arpc_pkg, arpc_front and arpc_back.
`timescale 1ns / 1ps
`default_nettype none
// Usage: drive an item on the input ports with start high while busy is
// low; that edge accepts the transaction. busy then stays high until the
// result has been shown; for a tick or a malformed packet it falls as done
// rises. Each item yields exactly one result, shown for one cycle with done
// high; the receiver cannot stall it. Timing is set by the back end, which
// visits one table entry per cycle: a tick or a malformed packet skips the
// table; an add, lookup or packet searches until a match or the last of
// TABLE_ENTRIES entries, after a sweep of all TABLE_ENTRIES entries when an
// aging sweep is due. The next item can start the cycle after done.
// The APB port writes own_ip (0x0), own_mac (0x8), sweep_interval_s (0x10)
// and max_age_s (0x18); write only while idle. Reads return the values.
// Reset (synchronous, active high) leaves the static broadcast entry in
// slot 0, clears the clock of seconds and restores register defaults.
module arp_cache_responder #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  action,
  input  wire logic [31:0] ip_address,
  input  wire logic [47:0] sender_mac,
  input  wire logic        is_dynamic,
  input  wire logic [15:0] hw_type,
  input  wire logic [15:0] proto_type,
  input  wire logic [7:0]  hw_len,
  input  wire logic [7:0]  proto_len,
  input  wire logic [15:0] opcode,
  input  wire logic [31:0] target_ip,
  output logic             done,
  output logic             hit,
  output logic [47:0]      found_mac,
  output logic             send_reply,
  output logic [47:0]      reply_mac,
  output logic [31:0]      reply_ip,
  output logic [1:0]       status,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  logic [31:0] own_ip;
  logic [47:0] own_mac;
  logic [15:0] sweep_interval_s;
  logic [15:0] max_age_s;
  logic [1:0]  reg_sel;
  logic        cmd_valid, cmd_pop;
  arpc_pkg::cmd_t cmd;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:3];

  // Registers are 8 bytes apart since own_mac needs more than 32 bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip           <= '0;
      own_mac          <= '0;
      sweep_interval_s <= arpc_pkg::SWEEP_RESET;
      max_age_s        <= arpc_pkg::AGE_RESET;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
      case (reg_sel)
        arpc_pkg::REG_OWN_IP:   own_ip           <= pwdata[31:0];
        arpc_pkg::REG_OWN_MAC:  own_mac          <= pwdata[47:0];
        arpc_pkg::REG_SWEEP_IV: sweep_interval_s <= pwdata[15:0];
        arpc_pkg::REG_MAX_AGE:  max_age_s        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      arpc_pkg::REG_OWN_IP:   prdata = {32'd0, own_ip};
      arpc_pkg::REG_OWN_MAC:  prdata = {16'd0, own_mac};
      arpc_pkg::REG_SWEEP_IV: prdata = {48'd0, sweep_interval_s};
      arpc_pkg::REG_MAX_AGE:  prdata = {48'd0, max_age_s};
      default:                prdata = '0;
    endcase
  end

  arpc_front u_front (
    .clk, .rst, .start, .busy, .action, .ip_address, .sender_mac, .is_dynamic,
    .hw_type, .proto_type, .hw_len, .proto_len, .opcode, .target_ip, .own_ip,
    .cmd_valid, .cmd, .cmd_pop
  );

  arpc_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_pop, .sweep_interval_s, .max_age_s,
    .done, .hit, .found_mac, .send_reply, .reply_mac, .reply_ip, .status
  );

endmodule
`default_nettype wire
